[sv/pfde_pkg.sv]
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared sizes, command codes and helper types for the packed draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

    localparam int PANEL_WIDTH  = 800;
    localparam int PANEL_HEIGHT = 600;

    localparam int MONO_ROW  = (PANEL_WIDTH + 7) / 8;
    localparam int GREY_ROW  = (PANEL_WIDTH + 1) / 2;
    localparam int MONO_SIZE = MONO_ROW * PANEL_HEIGHT;
    localparam int GREY_SIZE = GREY_ROW * PANEL_HEIGHT;

    localparam int MONO_AW = $clog2(MONO_SIZE);
    localparam int GREY_AW = $clog2(GREY_SIZE);
    localparam int PX_W    = $clog2(PANEL_WIDTH);
    localparam int PY_W    = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

    typedef enum logic [2:0] {
        MODE_PIXEL = 3'd0,
        MODE_HRUN  = 3'd1,
        MODE_VRUN  = 3'd2,
        MODE_RECT  = 3'd3,
        MODE_LINE  = 3'd4,
        MODE_CLEAR = 3'd5,
        MODE_READ  = 3'd6,
        MODE_NONE  = 3'd7
    } mode_t;

    localparam logic [1:0] REG_ROTATION = 2'd0;
    localparam logic [1:0] REG_DEPTH    = 2'd1;

    // One store access from the sequencer to the store module.
    typedef struct packed {
        logic                 wr;
        logic                 rd;
        logic                 depth;
        logic [GREY_AW-1:0]   addr;
        logic [7:0]           data;
    } mem_req_t;

endpackage

[sv/pfde_store.sv]
// ----------------------------------------------------------------------------
// pfde_store
// The mono and grey frame stores, each a single-port synchronous RAM with
// a registered read.
// ----------------------------------------------------------------------------
module pfde_store (
    input  logic               aclk,
    input  pfde_pkg::mem_req_t req,
    output logic [7:0]         rdata
);
    logic [7:0] mono_mem [pfde_pkg::MONO_SIZE];
    logic [7:0] grey_mem [pfde_pkg::GREY_SIZE];
    logic [7:0] mono_q_reg;
    logic [7:0] grey_q_reg;
    logic       sel_reg;

    always_ff @(posedge aclk) begin
        if (!req.depth) begin
            if (req.wr) begin
                mono_mem[req.addr[pfde_pkg::MONO_AW-1:0]] <= req.data;
            end
            if (req.rd) begin
                mono_q_reg <= mono_mem[req.addr[pfde_pkg::MONO_AW-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.depth) begin
            if (req.wr) begin
                grey_mem[req.addr] <= req.data;
            end
            if (req.rd) begin
                grey_q_reg <= grey_mem[req.addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd) begin
            sel_reg <= req.depth;
        end
    end

    assign rdata = sel_reg ? grey_q_reg : mono_q_reg;
endmodule

[sv/packed_framebuffer_draw_engine_unit.sv]
// ----------------------------------------------------------------------------
// packed_framebuffer_draw_engine_unit
// Pixel, run, rectangle and line rasterizer over packed mono and grey stores.
// ----------------------------------------------------------------------------
// Each drawn pixel is one read-modify-write of a store byte and passes
// through step, clip and rotate, address, read and write; a line pixel that
// falls outside the bounds goes back to the walk after the clip. Runs and
// rectangles are clipped before the walk, so only lines, and a single pixel
// request, visit cells outside the bounds. Clear sweeps the active store one
// byte a cycle (60000 or 240000 bytes), and a depth write that selects the
// other store starts the same sweep once the write is done and the engine is
// idle; during a sweep no request is accepted. Right after reset the mono
// store is cleared and then the grey store, before the first request is
// taken. The result waits in an output register, and the next request is
// taken while it waits; that request then runs and holds its result until
// the register is free.
module packed_framebuffer_draw_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic signed [14:0] s_x_start,
    input  logic signed [14:0] s_y_start,
    input  logic signed [14:0] s_x_end,
    input  logic signed [14:0] s_y_end,
    input  logic signed [14:0] s_span_w,
    input  logic signed [14:0] s_span_h,
    input  logic [15:0] s_color,
    input  logic [17:0] s_read_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_mode_echo,
    output logic [7:0]  m_read_data
);
    localparam int AW = pfde_pkg::GREY_AW;
    localparam int PX_W_L = pfde_pkg::PX_W;
    localparam logic [1:0] REG_ROT_L = pfde_pkg::REG_ROTATION;
    localparam logic [1:0] REG_DEP_L = pfde_pkg::REG_DEPTH;

    typedef enum logic [3:0] {
        ST_INIT_MONO, ST_INIT_GREY, ST_IDLE, ST_SETUP, ST_RECT, ST_LINE,
        ST_ROT, ST_ADDR, ST_READ, ST_WRITE, ST_CLEAR, ST_RDWAIT, ST_RDDONE,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic [1:0] rot_reg;
    logic       depth_reg;
    logic       pend_clear_reg;
    logic [AW-1:0] cnt_reg;

    logic [2:0]  mode_reg;
    logic [15:0] color_reg;
    logic [17:0] raddr_reg;
    // Rectangle and line walking registers (17-bit signed covers all sums).
    logic signed [16:0] cx_reg, cy_reg, x0_reg, x1_reg, y1_reg;
    logic signed [16:0] ex_reg, ey_reg;
    logic signed [16:0] dx_reg, dy_reg, err_reg;
    logic               steep_reg, ystep_neg_reg, line_last_reg;
    logic signed [16:0] px_reg, py_reg;   // plot point, logical
    logic [PX_W_L-1:0]  ppx_reg;
    logic [pfde_pkg::PY_W-1:0] ppy_reg;
    logic [AW-1:0]      paddr_reg;
    state_t             ret_reg;

    logic        out_valid_reg;
    logic [2:0]  out_mode_reg;
    logic [7:0]  out_data_reg;

    pfde_pkg::mem_req_t req;
    logic [7:0] rdata;

    pfde_store u_store (
        .aclk  (aclk),
        .req   (req),
        .rdata (rdata)
    );

    logic signed [16:0] lw, lh;
    assign lw = rot_reg[0] ? 17'(pfde_pkg::PANEL_HEIGHT) : 17'(pfde_pkg::PANEL_WIDTH);
    assign lh = rot_reg[0] ? 17'(pfde_pkg::PANEL_WIDTH) : 17'(pfde_pkg::PANEL_HEIGHT);

    logic in_bounds;
    assign in_bounds = (px_reg >= 0) && (py_reg >= 0) && (px_reg < lw) && (py_reg < lh);

    logic [AW-1:0] clear_last;
    assign clear_last = depth_reg ? AW'(pfde_pkg::GREY_SIZE - 1)
                                  : AW'(pfde_pkg::MONO_SIZE - 1);

    assign s_ready = (state_reg == ST_IDLE) && !pend_clear_reg;
    assign m_valid     = out_valid_reg;
    assign m_mode_echo = out_mode_reg;
    assign m_read_data = out_data_reg;

    // Byte merge for the pixel being written.
    logic [7:0] merged;
    logic [7:0] bmask;
    always_comb begin
        bmask  = 8'(1) << ppx_reg[2:0];
        if (!depth_reg) begin
            merged = (rdata & ~bmask) | ((color_reg != 16'd0) ? bmask : 8'd0);
        end else if (ppx_reg[0]) begin
            merged = {rdata[7:4], 1'b0, color_reg[2:0]};
        end else begin
            merged = {1'b0, color_reg[2:0], rdata[3:0]};
        end
    end

    always_comb begin
        req = '0;
        req.depth = depth_reg;
        req.addr  = paddr_reg;
        unique case (state_reg)
            ST_INIT_MONO: begin
                req.wr = 1'b1; req.depth = 1'b0; req.addr = cnt_reg;
            end
            ST_INIT_GREY, ST_CLEAR: begin
                req.wr = 1'b1; req.addr = cnt_reg;
                if (state_reg == ST_INIT_GREY) req.depth = 1'b1;
            end
            ST_READ: req.rd = 1'b1;
            ST_WRITE: begin
                req.wr = 1'b1; req.data = merged;
            end
            ST_SETUP: begin
                req.rd   = 1'b1;
                req.addr = raddr_reg[AW-1:0];
            end
            default: ;
        endcase
    end

    logic signed [16:0] adx, ady, sx0, sy0, sx1, sy1;
    always_comb begin
        adx = (ex_reg > x0_reg) ? ex_reg - x0_reg : x0_reg - ex_reg;
        ady = (ey_reg > cy_reg) ? ey_reg - cy_reg : cy_reg - ey_reg;
        sx0 = x0_reg; sy0 = cy_reg; sx1 = ex_reg; sy1 = ey_reg;
    end

    logic signed [16:0] err_dec;
    assign err_dec = err_reg - dy_reg;

    logic rd_ok;
    assign rd_ok = depth_reg ? (raddr_reg < 18'(pfde_pkg::GREY_SIZE))
                             : (raddr_reg < 18'(pfde_pkg::MONO_SIZE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT_MONO;
            rot_reg        <= 2'd0;
            depth_reg      <= 1'b0;
            pend_clear_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            if (cfg_we) begin
                if (cfg_index == REG_ROT_L) rot_reg <= cfg_data;
                if (cfg_index == REG_DEP_L && cfg_data[0] != depth_reg) begin
                    depth_reg      <= cfg_data[0];
                    pend_clear_reg <= 1'b1;
                end
            end
            unique case (state_reg)
                ST_INIT_MONO: begin
                    cnt_reg <= cnt_reg + AW'(1);
                    if (cnt_reg == AW'(pfde_pkg::MONO_SIZE - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_INIT_GREY;
                    end
                end
                ST_INIT_GREY: begin
                    cnt_reg <= cnt_reg + AW'(1);
                    if (cnt_reg == AW'(pfde_pkg::GREY_SIZE - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (pend_clear_reg && !cfg_we) begin
                        pend_clear_reg <= 1'b0;
                        cnt_reg        <= '0;
                        mode_reg       <= 3'(pfde_pkg::MODE_NONE);
                        state_reg      <= ST_CLEAR;
                    end else if (s_valid && s_ready) begin
                        mode_reg  <= s_mode;
                        color_reg <= s_color;
                        raddr_reg <= s_read_addr;
                        x0_reg    <= 17'(s_x_start);
                        cx_reg    <= 17'(s_x_start) < 0 ? 17'sd0 : 17'(s_x_start);
                        cy_reg    <= 17'(s_y_start);
                        px_reg    <= 17'(s_x_start);
                        py_reg    <= 17'(s_y_start);
                        ex_reg    <= 17'(s_x_end);
                        ey_reg    <= 17'(s_y_end);
                        x1_reg    <= 17'(s_x_start) + ((s_mode == 3'(pfde_pkg::MODE_VRUN))
                                     ? 17'sd1 : 17'(s_span_w));
                        y1_reg    <= 17'(s_y_start) + ((s_mode == 3'(pfde_pkg::MODE_HRUN))
                                     ? 17'sd1 : 17'(s_span_h));
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    unique case (mode_reg)
                        3'(pfde_pkg::MODE_PIXEL): begin
                            ret_reg   <= ST_DONE;
                            state_reg <= ST_ROT;
                        end
                        3'(pfde_pkg::MODE_HRUN), 3'(pfde_pkg::MODE_VRUN),
                        3'(pfde_pkg::MODE_RECT): begin
                            if (cy_reg < 0) cy_reg <= 17'sd0;
                            x0_reg <= cx_reg;
                            if (x1_reg > lw) x1_reg <= lw;
                            if (y1_reg > lh) y1_reg <= lh;
                            state_reg <= ST_RECT;
                        end
                        3'(pfde_pkg::MODE_LINE): begin
                            steep_reg <= ady > adx;
                            if (ady > adx) begin
                                if (sy0 > sy1) begin
                                    x0_reg <= sy1; cy_reg <= sx1; x1_reg <= sy0; y1_reg <= sx0;
                                end else begin
                                    x0_reg <= sy0; cy_reg <= sx0; x1_reg <= sy1; y1_reg <= sx1;
                                end
                            end else begin
                                if (sx0 > sx1) begin
                                    x0_reg <= sx1; cy_reg <= sy1; x1_reg <= sx0; y1_reg <= sy0;
                                end else begin
                                    x0_reg <= sx0; cy_reg <= sy0; x1_reg <= sx1; y1_reg <= sy1;
                                end
                            end
                            state_reg <= ST_LINE;
                            line_last_reg <= 1'b1; // marks first cycle of line
                        end
                        3'(pfde_pkg::MODE_CLEAR): begin
                            cnt_reg   <= '0;
                            state_reg <= ST_CLEAR;
                        end
                        3'(pfde_pkg::MODE_READ): state_reg <= ST_RDWAIT;
                        default: state_reg <= ST_DONE;
                    endcase
                end
                ST_RECT: begin
                    // cx walks x0..x1-1, cy walks rows up to y1-1.
                    if (cy_reg >= y1_reg || x0_reg >= x1_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        px_reg  <= cx_reg;
                        py_reg  <= cy_reg;
                        ret_reg <= ST_RECT;
                        state_reg <= ST_ROT;
                        if (cx_reg + 17'sd1 >= x1_reg) begin
                            cx_reg <= x0_reg;
                            cy_reg <= cy_reg + 17'sd1;
                        end else begin
                            cx_reg <= cx_reg + 17'sd1;
                        end
                    end
                end
                ST_LINE: begin
                    if (line_last_reg) begin
                        // Deltas are set on the first pass after ordering.
                        line_last_reg <= 1'b0;
                        dx_reg  <= x1_reg - x0_reg;
                        dy_reg  <= (y1_reg > cy_reg) ? y1_reg - cy_reg : cy_reg - y1_reg;
                        err_reg <= (x1_reg - x0_reg) >>> 1;
                        ystep_neg_reg <= !(cy_reg < y1_reg);
                    end else if (x0_reg > x1_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        px_reg  <= steep_reg ? cy_reg : x0_reg;
                        py_reg  <= steep_reg ? x0_reg : cy_reg;
                        ret_reg <= ST_LINE;
                        state_reg <= ST_ROT;
                        x0_reg  <= x0_reg + 17'sd1;
                        if (err_dec < 0) begin
                            cy_reg  <= ystep_neg_reg ? cy_reg - 17'sd1 : cy_reg + 17'sd1;
                            err_reg <= err_dec + dx_reg;
                        end else begin
                            err_reg <= err_dec;
                        end
                    end
                end
                ST_ROT: begin
                    if (!in_bounds) begin
                        state_reg <= ret_reg;
                    end else begin
                        unique case (rot_reg)
                            2'd1: begin
                                ppx_reg <= PX_W_L'(17'(pfde_pkg::PANEL_WIDTH - 1) - py_reg);
                                ppy_reg <= pfde_pkg::PY_W'(px_reg);
                            end
                            2'd2: begin
                                ppx_reg <= PX_W_L'(17'(pfde_pkg::PANEL_WIDTH - 1) - px_reg);
                                ppy_reg <= pfde_pkg::PY_W'(17'(pfde_pkg::PANEL_HEIGHT - 1)
                                           - py_reg);
                            end
                            2'd3: begin
                                ppx_reg <= PX_W_L'(py_reg);
                                ppy_reg <= pfde_pkg::PY_W'(17'(pfde_pkg::PANEL_HEIGHT - 1)
                                           - px_reg);
                            end
                            default: begin
                                ppx_reg <= PX_W_L'(px_reg);
                                ppy_reg <= pfde_pkg::PY_W'(py_reg);
                            end
                        endcase
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    paddr_reg <= depth_reg
                        ? AW'(ppy_reg * AW'(pfde_pkg::GREY_ROW)) + AW'(ppx_reg >> 1)
                        : AW'(ppy_reg * AW'(pfde_pkg::MONO_ROW)) + AW'(ppx_reg >> 3);
                    state_reg <= ST_READ;
                end
                ST_READ:  state_reg <= ST_WRITE;
                ST_WRITE: state_reg <= ret_reg;
                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + AW'(1);
                    if (cnt_reg == clear_last) begin
                        cnt_reg   <= '0;
                        state_reg <= (mode_reg == 3'(pfde_pkg::MODE_CLEAR)) ? ST_DONE : ST_IDLE;
                    end
                end
                ST_RDWAIT: state_reg <= ST_RDDONE;
                ST_RDDONE: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_mode_reg  <= mode_reg;
                        out_data_reg  <= rd_ok ? rdata : 8'd0;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_mode_reg  <= mode_reg;
                        out_data_reg  <= 8'd0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // A request is never taken during a store sweep, and a stalled result
    // holds still until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("request accepted during clear sweep");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_data)))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> $past(state_reg == ST_READ))
        else $error("store write without a preceding read");
endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packed frame-store draw engine. Draw, clear and
// read requests go through a shadow copy of both stores, and every read-back
// byte and command echo is checked in order. Rotation and depth are swept
// across phases, written while no request is outstanding.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIMIT = 6_000_000;

    typedef struct {
        logic [2:0]         mode;
        logic signed [14:0] xs, ys, xe, ye, w, h;
        logic [15:0]        color;
        logic [17:0]        addr;
    } draw_req_t;

    typedef struct {
        logic [2:0] mode;
        logic [7:0] data;
    } echo_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [1:0]  cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_mode = '0;
    logic signed [14:0] s_x_start = '0, s_y_start = '0, s_x_end = '0, s_y_end = '0;
    logic signed [14:0] s_span_w = '0, s_span_h = '0;
    logic [15:0] s_color = '0;
    logic [17:0] s_read_addr = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_mode_echo;
    logic [7:0]  m_read_data;

    packed_framebuffer_draw_engine_unit u_dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Shadow stores and register copies.
    logic [7:0] mono_shadow [pfde_pkg::MONO_SIZE];
    logic [7:0] grey_shadow [pfde_pkg::GREY_SIZE];
    logic [1:0] rot_q = 0;
    logic       depth_q = 0;

    draw_req_t pending_reqs[$];
    echo_t     echo_q[$];
    int n_acc = 0, n_res = 0, n_reads = 0, n_err = 0, cycles = 0;
    logic req_acc = 0;
    int hold_cnt = 0;
    bit hold_done = 0;

    function automatic int log_w();
        return rot_q[0] ? pfde_pkg::PANEL_HEIGHT : pfde_pkg::PANEL_WIDTH;
    endfunction

    function automatic int log_h();
        return rot_q[0] ? pfde_pkg::PANEL_WIDTH : pfde_pkg::PANEL_HEIGHT;
    endfunction

    function automatic void wipe_active();
        if (!depth_q) foreach (mono_shadow[i]) mono_shadow[i] = 8'h00;
        else foreach (grey_shadow[i]) grey_shadow[i] = 8'h00;
    endfunction

    function automatic void panel_xy(int x, int y, output int px, output int py);
        case (rot_q)
            2'd1: begin px = pfde_pkg::PANEL_WIDTH - 1 - y; py = x; end
            2'd2: begin
                px = pfde_pkg::PANEL_WIDTH - 1 - x;
                py = pfde_pkg::PANEL_HEIGHT - 1 - y;
            end
            2'd3: begin px = y; py = pfde_pkg::PANEL_HEIGHT - 1 - x; end
            default: begin px = x; py = y; end
        endcase
    endfunction

    function automatic int byte_addr(int x, int y);
        int px, py;
        panel_xy(x, y, px, py);
        return depth_q ? py * pfde_pkg::GREY_ROW + (px >> 1)
                       : py * pfde_pkg::MONO_ROW + (px >> 3);
    endfunction

    function automatic void put_pixel(int x, int y, logic [15:0] color);
        int px, py, a;
        logic [7:0] m;
        if (x < 0 || y < 0 || x >= log_w() || y >= log_h()) return;
        panel_xy(x, y, px, py);
        if (!depth_q) begin
            a = py * pfde_pkg::MONO_ROW + (px >> 3);
            m = 8'(1 << (px & 7));
            mono_shadow[a] = (mono_shadow[a] & ~m) | ((color != 0) ? m : 8'h00);
        end else begin
            a = py * pfde_pkg::GREY_ROW + (px >> 1);
            if (px & 1) grey_shadow[a] = {grey_shadow[a][7:4], 1'b0, color[2:0]};
            else grey_shadow[a] = {1'b0, color[2:0], grey_shadow[a][3:0]};
        end
    endfunction

    function automatic void fill_box(int x, int y, int w, int h, logic [15:0] color);
        int x0, y0, x1, y1;
        x0 = x < 0 ? 0 : x;
        y0 = y < 0 ? 0 : y;
        x1 = x + w;
        y1 = y + h;
        if (x1 > log_w()) x1 = log_w();
        if (y1 > log_h()) y1 = log_h();
        for (int i = y0; i < y1; i++)
            for (int j = x0; j < x1; j++) put_pixel(j, i, color);
    endfunction

    function automatic int iabs(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void trace_line(int x0, int y0, int x1, int y1, logic [15:0] color);
        bit steep;
        int t, dx, dy, err, ystep;
        steep = iabs(y1 - y0) > iabs(x1 - x0);
        if (steep) begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
        end
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        dx = x1 - x0;
        dy = iabs(y1 - y0);
        err = dx >>> 1;
        ystep = (y0 < y1) ? 1 : -1;
        for (; x0 <= x1; x0++) begin
            if (steep) put_pixel(y0, x0, color);
            else put_pixel(x0, y0, color);
            err -= dy;
            if (err < 0) begin
                y0 += ystep;
                err += dx;
            end
        end
    endfunction

    function automatic echo_t draw_predict(draw_req_t r);
        echo_t e;
        e.mode = r.mode;
        e.data = 8'h00;
        case (pfde_pkg::mode_t'(r.mode))
            pfde_pkg::MODE_PIXEL: put_pixel(r.xs, r.ys, r.color);
            pfde_pkg::MODE_HRUN:  fill_box(r.xs, r.ys, r.w, 1, r.color);
            pfde_pkg::MODE_VRUN:  fill_box(r.xs, r.ys, 1, r.h, r.color);
            pfde_pkg::MODE_RECT:  fill_box(r.xs, r.ys, r.w, r.h, r.color);
            pfde_pkg::MODE_LINE:  trace_line(r.xs, r.ys, r.xe, r.ye, r.color);
            pfde_pkg::MODE_CLEAR: wipe_active();
            pfde_pkg::MODE_READ: begin
                if (!depth_q) begin
                    if (r.addr < pfde_pkg::MONO_SIZE) e.data = mono_shadow[r.addr];
                end else if (r.addr < pfde_pkg::GREY_SIZE) begin
                    e.data = grey_shadow[r.addr];
                end
            end
            default: ;
        endcase
        return e;
    endfunction

    // Register writes, accepted requests and returned results, all at the rising edge.
    always @(posedge aclk) begin
        echo_t e;
        cycles <= cycles + 1;
        req_acc <= s_valid && s_ready;
        if (aresetn && cfg_we) begin
            if (cfg_index == pfde_pkg::REG_ROTATION) rot_q = cfg_data;
            else if (cfg_index == pfde_pkg::REG_DEPTH && cfg_data[0] != depth_q) begin
                depth_q = cfg_data[0];
                wipe_active();
            end
        end
        if (aresetn && s_valid && s_ready) begin
            echo_q.push_back(draw_predict('{s_mode, s_x_start, s_y_start, s_x_end,
                s_y_end, s_span_w, s_span_h, s_color, s_read_addr}));
            n_acc <= n_acc + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            n_res <= n_res + 1;
            if (echo_q.size() == 0) begin
                $error("result with no request outstanding: mode_echo %0d", m_mode_echo);
                n_err++;
            end else begin
                e = echo_q.pop_front();
                if (m_mode_echo !== e.mode) begin
                    $error("mode_echo expected %0d actual %0d", e.mode, m_mode_echo);
                    n_err++;
                end
                if (m_read_data !== e.data) begin
                    $error("read_data expected %0h actual %0h", e.data, m_read_data);
                    n_err++;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("[packed_framebuffer_draw_engine_unit] ERROR");
            $finish;
        end
    end

    // No idling on either side during this window of requests.
    function automatic bit quiet();
        return n_acc >= 900 && n_acc < 1200;
    endfunction

    always @(negedge aclk) begin
        draw_req_t r;
        if (!aresetn) begin
            s_valid <= 0;
        end else if (!s_valid || req_acc) begin
            if (pending_reqs.size() > 0 && (quiet() || $urandom_range(0, 99) >= 7)) begin
                r = pending_reqs.pop_front();
                s_valid <= 1;
                s_mode <= r.mode;
                s_x_start <= r.xs;
                s_y_start <= r.ys;
                s_x_end <= r.xe;
                s_y_end <= r.ye;
                s_span_w <= r.w;
                s_span_h <= r.h;
                s_color <= r.color;
                s_read_addr <= r.addr;
            end else begin
                s_valid <= 0;
            end
        end
    end

    // The receiver stalls once for a long stretch so the engine backs up.
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 0;
        end else if (n_acc >= 600 && !hold_done) begin
            hold_done <= 1;
            hold_cnt <= 400;
            m_ready <= 0;
        end else begin
            m_ready <= aresetn && (quiet() || $urandom_range(0, 99) >= 7);
        end
    end

    function automatic draw_req_t mk(int mode, int xs, int ys, int xe, int ye, int w, int h,
                                     int color, int addr);
        draw_req_t r;
        r.mode = 3'(mode);
        r.xs = 15'(xs);
        r.ys = 15'(ys);
        r.xe = 15'(xe);
        r.ye = 15'(ye);
        r.w = 15'(w);
        r.h = 15'(h);
        r.color = 16'(color);
        r.addr = 18'(addr);
        return r;
    endfunction

    function automatic int near_coord(int lim);
        int base;
        base = $urandom_range(0, 1) ? 0 : lim - 36;
        return base + $urandom_range(0, 40) - 4;
    endfunction

    function automatic draw_req_t random_req();
        draw_req_t r;
        int sel, x, y;
        bit noise;
        sel = $urandom_range(0, 99);
        noise = $urandom_range(0, 99) < 3;
        x = near_coord(log_w());
        y = near_coord(log_h());
        r = mk(0, x, y, x + $urandom_range(0, 14) - 7, y + $urandom_range(0, 14) - 7,
               $urandom_range(0, 15) - 3, $urandom_range(0, 15) - 3,
               $urandom_range(0, 9) == 0 ? 0 : $urandom, 0);
        r.addr = 18'(byte_addr(near_coord(log_w()), near_coord(log_h())));
        if (sel < 20) r.mode = pfde_pkg::MODE_PIXEL;
        else if (sel < 32) r.mode = pfde_pkg::MODE_HRUN;
        else if (sel < 44) r.mode = pfde_pkg::MODE_VRUN;
        else if (sel < 56) r.mode = pfde_pkg::MODE_RECT;
        else if (sel < 68) r.mode = pfde_pkg::MODE_LINE;
        else if (sel < 98) r.mode = pfde_pkg::MODE_READ;
        else r.mode = pfde_pkg::MODE_NONE;
        if (noise) begin
            // Far-flung coordinates and spans, kept cheap to rasterize.
            r.xs = 15'($urandom);
            r.xe = r.xs + 15'($urandom_range(0, 6));
            r.ye = r.ys + 15'($urandom_range(0, 6));
            r.w = 15'($urandom);
            r.h = 15'($urandom_range(0, 1) ? $urandom : -($urandom_range(0, 16383)));
            if (r.mode == pfde_pkg::MODE_RECT) r.h = 15'($urandom_range(0, 4));
            if (r.mode == pfde_pkg::MODE_HRUN && $urandom_range(0, 1)) r.xs = 15'(x);
            if (r.mode == pfde_pkg::MODE_PIXEL) r.ys = 15'($urandom);
        end
        if (r.mode == pfde_pkg::MODE_READ) begin
            sel = $urandom_range(0, 99);
            n_reads++;
            if (sel < 15) begin
                r.addr = 18'($urandom_range(0, depth_q ? pfde_pkg::GREY_SIZE - 1
                                                       : pfde_pkg::MONO_SIZE - 1));
            end else if (sel < 30) begin
                r.addr = 18'($urandom);
            end
        end
        return r;
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [1:0] val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        @(negedge aclk);
        while (pending_reqs.size() > 0 || s_valid || echo_q.size() > 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic random_phase(int n);
        repeat (n) pending_reqs.push_back(random_req());
        drain();
    endtask

    initial begin
        int wl, hl;
        repeat (5) @(negedge aclk);
        aresetn <= 1;

        // Directed requests in mono with no rotation.
        wl = log_w();
        hl = log_h();
        pending_reqs.push_back(mk(pfde_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_PIXEL, wl - 1, hl - 1, 0, 0, 0, 0, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_PIXEL, -1, 0, 0, 0, 0, 0, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_PIXEL, wl, hl, 0, 0, 0, 0, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_PIXEL, -16384, 16383, 16383, -16384,
                                  0, 0, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_HRUN, -3, 1, 0, 0, 12, -16384, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_HRUN, 2, 2, 0, 0, 0, 5, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_HRUN, 2, 2, 0, 0, -5, 5, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_VRUN, 9, -2, 0, 0, 16383, 6, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_RECT, wl - 3, hl - 2, 0, 0, 8, 8, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_RECT, 16, 4, 0, 0, 5, 3, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_PIXEL, 17, 5, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_LINE, 0, 10, 12, 10, 0, 0, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_LINE, 30, 20, 30, 8, 0, 0, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_LINE, 24, 12, 20, 2, 0, 0, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_LINE, -5, -3, 4, 3, 0, 0, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_LINE, 5, 5, 5, 5, 0, 0, 1, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0,
                                  pfde_pkg::MONO_ROW + 1));
        pending_reqs.push_back(mk(pfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0,
                                  pfde_pkg::MONO_SIZE - 1));
        pending_reqs.push_back(mk(pfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0,
                                  pfde_pkg::MONO_SIZE));
        pending_reqs.push_back(mk(pfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 18'h3FFFF));
        pending_reqs.push_back(mk(pfde_pkg::MODE_NONE, -1, -1, -1, -1, -1, -1, 16'hFFFF,
                                  18'h3FFFF));
        pending_reqs.push_back(mk(pfde_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk(pfde_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        random_phase(200);
        for (int r = 1; r < 4; r++) begin
            reg_write(pfde_pkg::REG_ROTATION, 2'(r));
            random_phase(200);
        end
        // The index beyond the list must be ignored.
        reg_write(2'd3, 2'd3);
        random_phase(40);

        // Grey store: this write clears it.
        reg_write(pfde_pkg::REG_DEPTH, 2'b01);
        for (int r = 0; r < 4; r++) begin
            reg_write(pfde_pkg::REG_ROTATION, 2'(3 - r));
            random_phase(220);
        end
        // Same depth again with the upper bit set: no clear.
        reg_write(pfde_pkg::REG_DEPTH, 2'b11);
        random_phase(60);

        // Back to mono, which clears it once more.
        reg_write(pfde_pkg::REG_DEPTH, 2'b10);
        reg_write(pfde_pkg::REG_ROTATION, 2'd0);
        random_phase(150);

        $display("Covered %0d requests (%0d random reads) and %0d results", n_acc, n_reads,
                 n_res);
        $display("over all four rotations, both store depths and every command.");
        if (n_err == 0) $display("[packed_framebuffer_draw_engine_unit] OK");
        else $display("[packed_framebuffer_draw_engine_unit] ERROR");
        $finish;
    end

endmodule
